>>> hdl/brr_pkg.sv
// Shared types and constants of the bilinear RGB resize engine.
// No dependencies; the engine top level and the testbench take it in.
`timescale 1ns / 1ps

package brr_pkg;

    // Field widths fixed by the word formats
    localparam int CHAN_W   = 8;
    localparam int PIXEL_W  = 3 * CHAN_W;
    localparam int INDEX_W  = 18;
    localparam int COORD_W  = 10;
    localparam int SIZE_W   = 10;
    localparam int STEP_W   = 26;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = COORD_W + STEP_W;
    localparam int IPART_W  = POS_W - FRAC_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = STEP_W;

    // Command codes
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y        = 8'd3;

    // Register reset values
    localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST  = 10'd512;
    localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST = 10'd512;
    localparam logic [STEP_W-1:0] STEP_X_RST        = 26'd65536;
    localparam logic [STEP_W-1:0] STEP_Y_RST        = 26'd65536;

    typedef struct packed {
        cmd_t                command;
        logic [INDEX_W-1:0]  pixel_index;
        logic [CHAN_W-1:0]   blue_in;
        logic [CHAN_W-1:0]   green_in;
        logic [CHAN_W-1:0]   red_in;
        logic [COORD_W-1:0]  target_x;
        logic [COORD_W-1:0]  target_y;
    } in_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
    } out_word_t;

endpackage

>>> hdl/brr_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used as the frame store of the resize engine.
`timescale 1ns / 1ps

module brr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 262144
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, or read into the output register; the output holds between reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/bilinear_rgb_resize.sv
// Bilinear RGB resize engine: frame store, coordinate pipeline, blend pipeline.
// Depends on brr_pkg and brr_ram.
//
//  channel | ports                              | direction | word
//  --------+------------------------------------+-----------+-----------------------------
//  s_      | s_valid, s_ready, s_data           | in        | write pixel or query pixel
//  m_      | m_valid, m_ready, m_data           | out       | interpolated R, G, B
//  cfg_    | cfg_valid, cfg_ready, cfg_index,   | in        | register write
//          | cfg_data                           |           |
//
// A write word makes one access to the frame store; a query word makes four, one per
// neighbour read on the single store port, so a query holds the store until its last read.
// A query passes stages 1 to 3, the store read register, blend stage 1 and the output register.
// Reset clears control state and registers; the frame store is not cleared.
// A stall on m_ready backs up through the blend stages into the store sequencer and
// the coordinate stages; no word is dropped or repeated.
`timescale 1ns / 1ps

module bilinear_rgb_resize #(
    parameter int MAX_SRC_WIDTH  = 512,
    parameter int MAX_SRC_HEIGHT = 512,
    parameter int MAX_OUT_DIM    = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  brr_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output brr_pkg::out_word_t                  m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [brr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [brr_pkg::CFG_DAT_W-1:0]       cfg_data
);

    import brr_pkg::*;

    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_SRC_WIDTH + 1);
    localparam int HB    = $clog2(MAX_SRC_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] source_width_reg, source_height_reg;
    logic [STEP_W-1:0] step_x_reg, step_y_reg;

    assign cfg_ready = 1'b1;

    // Take register writes; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_width_reg  <= SOURCE_WIDTH_RST;
            source_height_reg <= SOURCE_HEIGHT_RST;
            step_x_reg        <= STEP_X_RST;
            step_y_reg        <= STEP_Y_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_STEP_X:        step_x_reg        <= cfg_data[STEP_W-1:0];
                CFG_STEP_Y:        step_y_reg        <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the image size to 1..maximum
    logic [WB-1:0] eff_w;
    logic [HB-1:0] eff_h;

    always_comb begin
        if (source_width_reg == '0) begin
            eff_w = WB'(1);
        end else if (32'(source_width_reg) > MAX_SRC_WIDTH) begin
            eff_w = WB'(MAX_SRC_WIDTH);
        end else begin
            eff_w = WB'(source_width_reg);
        end
        if (source_height_reg == '0) begin
            eff_h = HB'(1);
        end else if (32'(source_height_reg) > MAX_SRC_HEIGHT) begin
            eff_h = HB'(MAX_SRC_HEIGHT);
        end else begin
            eff_h = HB'(source_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake chain
    // ------------------------------------------------------------------
    logic s1_ready, s2_ready, s3_ready;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic b1_ready, b1_take, b1_valid_reg, b2_take, out_ready;
    logic m_valid_reg;

    assign out_ready = !m_valid_reg || m_ready;
    assign b2_take   = b1_valid_reg && out_ready;
    assign b1_ready  = !b1_valid_reg || b2_take;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s_ready   = s1_ready;

    // ------------------------------------------------------------------
    // Stage 1: saturate targets, source position = target * step
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] tx_sat, ty_sat;
    cmd_t               s1_cmd_reg;
    logic               s1_wr_ok_reg;
    logic [AW-1:0]      s1_wr_addr_reg;
    logic [PIXEL_W-1:0] s1_wr_pix_reg;
    logic [POS_W-1:0]   s1_pos_x_reg, s1_pos_y_reg;

    always_comb begin
        tx_sat = (32'(s_data.target_x) >= MAX_OUT_DIM) ? COORD_W'(MAX_OUT_DIM - 1)
                                                        : s_data.target_x;
        ty_sat = (32'(s_data.target_y) >= MAX_OUT_DIM) ? COORD_W'(MAX_OUT_DIM - 1)
                                                        : s_data.target_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s_valid;
        end
        if (s_valid && s1_ready) begin
            s1_cmd_reg     <= s_data.command;
            s1_wr_ok_reg   <= (32'(s_data.pixel_index) < DEPTH);
            s1_wr_addr_reg <= AW'(s_data.pixel_index);
            s1_wr_pix_reg  <= {s_data.red_in, s_data.green_in, s_data.blue_in};
            s1_pos_x_reg   <= POS_W'(tx_sat) * POS_W'(step_x_reg);
            s1_pos_y_reg   <= POS_W'(ty_sat) * POS_W'(step_y_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: split integer part and fraction, clamp at last column and row
    // ------------------------------------------------------------------
    logic [IPART_W-1:0] ix, iy;
    logic               x_edge, y_edge;
    cmd_t               s2_cmd_reg;
    logic               s2_wr_ok_reg;
    logic [AW-1:0]      s2_wr_addr_reg;
    logic [PIXEL_W-1:0] s2_wr_pix_reg;
    logic [XW-1:0]      s2_x0_reg;
    logic [YW-1:0]      s2_y0_reg;
    logic               s2_xs_reg, s2_ys_reg;
    logic [FRAC_W-1:0]  s2_fx_reg, s2_fy_reg;

    always_comb begin
        ix     = s1_pos_x_reg[POS_W-1:FRAC_W];
        iy     = s1_pos_y_reg[POS_W-1:FRAC_W];
        x_edge = (32'(ix) >= 32'(eff_w) - 32'd1);
        y_edge = (32'(iy) >= 32'(eff_h) - 32'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (s1_valid_reg && s2_ready) begin
            s2_cmd_reg     <= s1_cmd_reg;
            s2_wr_ok_reg   <= s1_wr_ok_reg;
            s2_wr_addr_reg <= s1_wr_addr_reg;
            s2_wr_pix_reg  <= s1_wr_pix_reg;
            s2_x0_reg      <= x_edge ? XW'(32'(eff_w) - 32'd1) : XW'(ix);
            s2_y0_reg      <= y_edge ? YW'(32'(eff_h) - 32'd1) : YW'(iy);
            s2_xs_reg      <= !x_edge;
            s2_ys_reg      <= !y_edge;
            s2_fx_reg      <= s1_pos_x_reg[FRAC_W-1:0];
            s2_fy_reg      <= s1_pos_y_reg[FRAC_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: row base = y0 * width; this stage feeds the store sequencer
    // ------------------------------------------------------------------
    logic [YW+WB-1:0]   row_prod;
    cmd_t               s3_cmd_reg;
    logic               s3_wr_ok_reg;
    logic [AW-1:0]      s3_wr_addr_reg;
    logic [PIXEL_W-1:0] s3_wr_pix_reg;
    logic [AW-1:0]      s3_row0_reg;
    logic [XW-1:0]      s3_x0_reg;
    logic               s3_xs_reg, s3_ys_reg;
    logic [FRAC_W-1:0]  s3_fx_reg, s3_fy_reg;

    assign row_prod = (YW+WB)'(s2_y0_reg) * (YW+WB)'(eff_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s3_ready) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (s2_valid_reg && s3_ready) begin
            s3_cmd_reg     <= s2_cmd_reg;
            s3_wr_ok_reg   <= s2_wr_ok_reg;
            s3_wr_addr_reg <= s2_wr_addr_reg;
            s3_wr_pix_reg  <= s2_wr_pix_reg;
            s3_row0_reg    <= AW'(row_prod);
            s3_x0_reg      <= s2_x0_reg;
            s3_xs_reg      <= s2_xs_reg;
            s3_ys_reg      <= s2_ys_reg;
            s3_fx_reg      <= s2_fx_reg;
            s3_fy_reg      <= s2_fy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Store sequencer: one write, or four neighbour reads in the order
    // upper-left, upper-right, lower-left, lower-right
    // ------------------------------------------------------------------
    logic [1:0]         cnt_reg;
    logic               pend_reg;
    logic               rd_vld_reg;
    logic [1:0]         rd_sel_reg;
    logic [PIXEL_W-1:0] g00_reg, g01_reg, g10_reg;
    logic [FRAC_W-1:0]  pend_fx_reg, pend_fy_reg;
    logic               is_query, rd_ok, issue_rd, issue_wr, last_rd;
    logic [AW-1:0]      rd_addr, ram_addr;
    logic [PIXEL_W-1:0] ram_rdata;

    always_comb begin
        is_query = (s3_cmd_reg == CMD_QUERY);
        // The last neighbour waits in the store's read register until taken
        rd_ok    = !pend_reg || b1_take;
        issue_rd = s3_valid_reg && is_query && rd_ok;
        issue_wr = s3_valid_reg && !is_query && s3_wr_ok_reg;
        last_rd  = issue_rd && (cnt_reg == 2'd3);
        s3_ready = !s3_valid_reg || !is_query || last_rd;
        rd_addr  = s3_row0_reg + AW'(s3_x0_reg)
                 + ((cnt_reg[1] && s3_ys_reg) ? AW'(eff_w) : AW'(0))
                 + ((cnt_reg[0] && s3_xs_reg) ? AW'(1) : AW'(0));
        ram_addr = is_query ? rd_addr : s3_wr_addr_reg;
    end

    assign b1_take = pend_reg && b1_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            pend_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (issue_rd) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            pend_reg   <= (pend_reg && !b1_take) || last_rd;
            rd_vld_reg <= issue_rd;
        end
        rd_sel_reg <= cnt_reg;
        if (last_rd) begin
            pend_fx_reg <= s3_fx_reg;
            pend_fy_reg <= s3_fy_reg;
        end
        // Gather the first three neighbours as they return
        if (rd_vld_reg) begin
            case (rd_sel_reg)
                2'd0:    g00_reg <= ram_rdata;
                2'd1:    g01_reg <= ram_rdata;
                2'd2:    g10_reg <= ram_rdata;
                default: ;
            endcase
        end
    end

    brr_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk  (aclk),
        .we    (issue_wr),
        .re    (issue_rd),
        .addr  (ram_addr),
        .wdata (s3_wr_pix_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Blend stage 1: horizontal blend per channel, top = a*2^16 + (b - a)*fx
    // ------------------------------------------------------------------
    logic [23:0]       top_next [3];
    logic [23:0]       bot_next [3];
    logic [23:0]       b1_top_reg [3];
    logic [23:0]       b1_bot_reg [3];
    logic [FRAC_W-1:0] b1_fy_reg;

    always_comb begin
        logic signed [8:0]  dt, db;
        logic signed [25:0] st, sb;
        for (int c = 0; c < 3; c++) begin
            dt = $signed({1'b0, g01_reg[CHAN_W*c +: CHAN_W]})
               - $signed({1'b0, g00_reg[CHAN_W*c +: CHAN_W]});
            db = $signed({1'b0, ram_rdata[CHAN_W*c +: CHAN_W]})
               - $signed({1'b0, g10_reg[CHAN_W*c +: CHAN_W]});
            st = $signed({2'b00, g00_reg[CHAN_W*c +: CHAN_W], 16'h0000})
               + dt * $signed({1'b0, pend_fx_reg});
            sb = $signed({2'b00, g10_reg[CHAN_W*c +: CHAN_W], 16'h0000})
               + db * $signed({1'b0, pend_fx_reg});
            top_next[c] = st[23:0];
            bot_next[c] = sb[23:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (b1_ready) begin
            b1_valid_reg <= pend_reg;
        end
        if (b1_take) begin
            b1_top_reg <= top_next;
            b1_bot_reg <= bot_next;
            b1_fy_reg  <= pend_fy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Blend stage 2: vertical blend, keep bits 39..32 of the Q.32 sum
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] chan_next [3];
    out_word_t         m_data_reg;

    always_comb begin
        logic signed [24:0] dv;
        logic signed [41:0] sv;
        for (int c = 0; c < 3; c++) begin
            dv = $signed({1'b0, b1_bot_reg[c]}) - $signed({1'b0, b1_top_reg[c]});
            sv = $signed({2'b00, b1_top_reg[c], 16'h0000})
               + dv * $signed({1'b0, b1_fy_reg});
            chan_next[c] = sv[39:32];
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= b1_valid_reg;
        end
        if (b2_take) begin
            m_data_reg.red_out   <= chan_next[2];
            m_data_reg.green_out <= chan_next[1];
            m_data_reg.blue_out  <= chan_next[0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> verif/bilinear_rgb_resize_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_rgb_resize: a directed table, then random phases.
// Depends on brr_pkg and the engine RTL; pixels are predicted in-line unless the table gives them.

module bilinear_rgb_resize_tb;
    import brr_pkg::*;

    localparam int MAX_W           = 512;
    localparam int MAX_H           = 512;
    localparam int MAX_OUT         = 1024;
    localparam int DEPTH           = MAX_W * MAX_H;
    localparam int DRAIN_CYCLES    = 16;
    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 35;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int IDLE_PCT        = 37;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // Shadow registers and frame store of the predictor
    logic [SIZE_W-1:0]  reg_width  = SOURCE_WIDTH_RST;
    logic [SIZE_W-1:0]  reg_height = SOURCE_HEIGHT_RST;
    logic [STEP_W-1:0]  reg_step_x = STEP_X_RST;
    logic [STEP_W-1:0]  reg_step_y = STEP_Y_RST;
    logic [PIXEL_W-1:0] pixel_mem   [DEPTH];
    bit                 pixel_known [DEPTH];
    int unsigned        known_len = 0;

    out_word_t   pending_pixels[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          idle_pct       = IDLE_PCT;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_DAT_W-1:0] reg_value;
        in_word_t             word;
        bit                   typed;
        out_word_t            want;
    } stim_row_t;

    stim_row_t stim_table[$];

    bilinear_rgb_resize #(
        .MAX_SRC_WIDTH  (MAX_W),
        .MAX_SRC_HEIGHT (MAX_H),
        .MAX_OUT_DIM    (MAX_OUT)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return 32'(v);
    endfunction

    // Map a target coordinate to its two neighbours and the Q.16 fraction
    function automatic void locate(input logic [COORD_W-1:0] tgt, input logic [STEP_W-1:0] step,
                                   input int unsigned size, output int unsigned i0,
                                   output int unsigned i1, output logic [FRAC_W-1:0] frac);
        logic [POS_W-1:0] pos;
        pos  = POS_W'(tgt) * POS_W'(step);
        frac = pos[FRAC_W-1:0];
        if (pos[POS_W-1:FRAC_W] >= size - 1) begin
            i0 = size - 1;
            i1 = size - 1;
        end else begin
            i0 = 32'(pos[POS_W-1:FRAC_W]);
            i1 = i0 + 1;
        end
    endfunction

    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a, b, c, d,
                                                     input logic [FRAC_W-1:0] fx, fy);
        logic [63:0] wx0, wx1, wy0, wy1, top, bot, sum;
        wx0 = 64'd65536 - 64'(fx);
        wx1 = 64'(fx);
        wy0 = 64'd65536 - 64'(fy);
        wy1 = 64'(fy);
        top = a * wx0 + b * wx1;
        bot = c * wx0 + d * wx1;
        sum = top * wy0 + bot * wy1;
        return sum[39:32];
    endfunction

    function automatic out_word_t interpolate(input logic [COORD_W-1:0] tx, ty);
        int unsigned        w, h, x0, x1, y0, y1;
        logic [FRAC_W-1:0]  fx, fy;
        logic [PIXEL_W-1:0] p00, p01, p10, p11;
        out_word_t          res;
        w = eff_size(reg_width, MAX_W);
        h = eff_size(reg_height, MAX_H);
        locate(tx, reg_step_x, w, x0, x1, fx);
        locate(ty, reg_step_y, h, y0, y1, fy);
        p00 = pixel_mem[INDEX_W'(y0 * w + x0)];
        p01 = pixel_mem[INDEX_W'(y0 * w + x1)];
        p10 = pixel_mem[INDEX_W'(y1 * w + x0)];
        p11 = pixel_mem[INDEX_W'(y1 * w + x1)];
        // Store layout: red 23..16, green 15..8, blue 7..0
        res.red_out   = blend_chan(p00[23:16], p01[23:16], p10[23:16], p11[23:16], fx, fy);
        res.green_out = blend_chan(p00[15:8], p01[15:8], p10[15:8], p11[15:8], fx, fy);
        res.blue_out  = blend_chan(p00[7:0], p01[7:0], p10[7:0], p11[7:0], fx, fy);
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one word, hold it until accepted, then update the prediction
    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.command == CMD_QUERY) begin
            pending_pixels.push_back(typed ? want : interpolate(w.target_x, w.target_y));
        end else begin
            pixel_mem[w.pixel_index]   = {w.red_in, w.green_in, w.blue_in};
            pixel_known[w.pixel_index] = 1'b1;
            while (known_len < DEPTH && pixel_known[INDEX_W'(known_len)]) known_len++;
        end
    endtask

    // Drop valid and let every expected pixel come out, plus the pipeline tail
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SOURCE_WIDTH:  reg_width  = val[SIZE_W-1:0];
            CFG_SOURCE_HEIGHT: reg_height = val[SIZE_W-1:0];
            CFG_STEP_X:        reg_step_x = val[STEP_W-1:0];
            CFG_STEP_Y:        reg_step_y = val[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    function automatic in_word_t random_word(input cmd_t cmd);
        logic [63:0] raw;
        in_word_t    w;
        raw       = {$urandom(), $urandom()};
        w         = raw[$bits(in_word_t)-1:0];
        w.command = cmd;
        return w;
    endfunction

    // Write the store in raster order until the first need entries are all known
    task automatic fill_frame(input int unsigned need);
        in_word_t w;
        while (known_len < need) begin
            w = random_word(CMD_WRITE);
            w.pixel_index = INDEX_W'(known_len);
            send_word(w, 1'b0, '0);
        end
    endtask

    // Step by the rule floor(in * 65536 / out), with a zero or a 2^25 step now and then
    function automatic logic [STEP_W-1:0] pick_step(input int unsigned size,
                                                    output int unsigned out_dim);
        int unsigned sel;
        sel     = $urandom_range(0, 9);
        out_dim = $urandom_range(1, 64);
        if (sel == 0) return '0;
        if (sel == 1) return STEP_W'(33554432);
        if (sel == 2) out_dim = $urandom_range(65, MAX_OUT);
        return STEP_W'((size * 65536) / out_dim);
    endfunction

    // ---------------------------------------------------------------- directed table

    task automatic tbl_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        stim_row_t row;
        row           = '{default: '0};
        row.is_cfg    = 1'b1;
        row.reg_index = idx;
        row.reg_value = val;
        stim_table.push_back(row);
    endtask

    task automatic tbl_write(input int unsigned idx, input logic [PIXEL_W-1:0] rgb);
        stim_row_t row;
        row                  = '{default: '0};
        row.word             = '0;
        row.word.command     = CMD_WRITE;
        row.word.pixel_index = INDEX_W'(idx);
        row.word.red_in      = rgb[23:16];
        row.word.green_in    = rgb[15:8];
        row.word.blue_in     = rgb[7:0];
        stim_table.push_back(row);
    endtask

    task automatic tbl_query(input int unsigned tx, ty, input bit typed,
                             input logic [PIXEL_W-1:0] rgb);
        stim_row_t row;
        row               = '{default: '0};
        row.word          = '0;
        row.word.command  = CMD_QUERY;
        row.word.target_x = COORD_W'(tx);
        row.word.target_y = COORD_W'(ty);
        row.typed         = typed;
        row.want          = rgb;
        stim_table.push_back(row);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_chan(input string chan, input logic [CHAN_W-1:0] want, got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %02h, actual %02h", $time, chan, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t ns: unexpected pixel, expected none, actual %06h", $time, m_data);
                mismatch_count++;
            end else begin
                want = pending_pixels.pop_front();
                check_chan("red", want.red_out, m_data.red_out);
                check_chan("green", want.green_out, m_data.green_out);
                check_chan("blue", want.blue_out, m_data.blue_out);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bilinear_rgb_resize_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin : stimulus
        logic [SIZE_W-1:0] wr, hr;
        logic [STEP_W-1:0] sx, sy;
        int unsigned       wsz, hsz, out_x, out_y, pick;
        in_word_t          w;

        // Reset settings: 512 x 512, unit step, so fractions are zero
        tbl_write(0, 24'h80_00_FF);
        tbl_write(1, 24'h11_22_33);
        tbl_write(512, 24'h44_55_66);
        tbl_write(513, 24'h77_88_99);
        tbl_query(0, 0, 1'b1, 24'h80_00_FF);
        // Right edge: column saturates at the last one
        tbl_write(511, 24'h00_FF_00);
        tbl_write(1023, 24'h12_34_56);
        tbl_query(600, 0, 1'b1, 24'h00_FF_00);
        // Last store entry, largest targets, both axes saturate
        tbl_write(DEPTH - 1, 24'hFF_FF_FF);
        tbl_query(1023, 1023, 1'b1, 24'hFF_FF_FF);
        // Oversized width clamps to the maximum, so the last column is column 511
        tbl_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(1023));
        tbl_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(1));
        tbl_query(1023, 0, 1'b1, 24'h00_FF_00);
        // 2 x 2 source, half step across, nearly full fraction down
        tbl_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(2));
        tbl_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(2));
        tbl_reg(CFG_STEP_X, 26'h000_8000);
        tbl_reg(CFG_STEP_Y, 26'h000_FFFF);
        tbl_write(0, 24'hFF_FF_FF);
        tbl_write(1, 24'hFF_FF_FF);
        tbl_write(2, 24'hFF_FF_FF);
        tbl_write(3, 24'hFF_FF_FF);
        tbl_query(1, 1, 1'b1, 24'hFF_FF_FF);
        tbl_write(3, 24'h00_00_00);
        tbl_query(1, 1, 1'b0, '0);
        tbl_query(1023, 1023, 1'b0, '0);
        // Zero width clamps to one, oversized height clamps, a 2^25 step and a zero step,
        // and a write to an unused index changes nothing
        tbl_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(0));
        tbl_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(1023));
        tbl_reg(CFG_STEP_X, 26'h200_0000);
        tbl_reg(CFG_STEP_Y, CFG_DAT_W'(0));
        tbl_reg(CFG_UNUSED, 26'h3FF_FFFF);
        tbl_query(1023, 1023, 1'b1, 24'hFF_FF_FF);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                wait_drained();
                write_reg(stim_table[k].reg_index, stim_table[k].reg_value);
            end else begin
                send_word(stim_table[k].word, stim_table[k].typed, stim_table[k].want);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            // One phase runs with no idling on either side
            idle_pct = (phase == 4) ? 0 : IDLE_PCT;
            case (phase)
                0: begin wr = 10'd2; hr = 10'd128; end
                1: begin wr = 10'd256; hr = 10'd1; end
                2: begin wr = 10'd0; hr = 10'd0; end
                3: begin wr = 10'd64; hr = SIZE_W'($urandom_range(1, 4)); end
                default: begin
                    wr = SIZE_W'($urandom_range(1, 16));
                    hr = SIZE_W'($urandom_range(1, 16));
                end
            endcase
            wsz = eff_size(wr, MAX_W);
            hsz = eff_size(hr, MAX_H);
            sx  = pick_step(wsz, out_x);
            sy  = pick_step(hsz, out_y);
            write_reg(CFG_SOURCE_WIDTH, CFG_DAT_W'(wr));
            write_reg(CFG_SOURCE_HEIGHT, CFG_DAT_W'(hr));
            write_reg(CFG_STEP_X, CFG_DAT_W'(sx));
            write_reg(CFG_STEP_Y, CFG_DAT_W'(sy));
            fill_frame(wsz * hsz);

            repeat (WORDS_PER_PHASE) begin
                // Hold off now and then until the pipeline is empty
                if ($urandom_range(0, 39) == 0) wait_drained();
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    w = random_word(CMD_QUERY);
                    if ($urandom_range(0, 9) != 0) begin
                        w.target_x = COORD_W'($urandom_range(0, out_x - 1));
                        w.target_y = COORD_W'($urandom_range(0, out_y - 1));
                    end
                end else begin
                    w = random_word(CMD_WRITE);
                    if (pick < 95) w.pixel_index = INDEX_W'($urandom_range(0, wsz * hsz - 1));
                end
                send_word(w, 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("bilinear_rgb_resize_tb: PASS");
        end else begin
            $display("bilinear_rgb_resize_tb: FAIL");
        end
        $finish;
    end

endmodule
